[rtl/supertrend_signal_macros.svh]
// assertion macros shared by the rtl
`ifndef SUPERTREND_SIGNAL_MACROS_SVH
`define SUPERTREND_SIGNAL_MACROS_SVH

`ifndef SYNTH
// condition holds in the same cycle
`define STS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("supertrend_signal: same-cycle check failed");
// condition holds in the next cycle
`define STS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("supertrend_signal: next-cycle check failed");
`else
`define STS_ASSERT_IMP(label, ante, cons)
`define STS_ASSERT_NXT(label, ante, cons)
`endif

`endif

[rtl/sts_pkg.sv]
package sts_pkg;

    localparam int PRICE_WIDTH = 32;
    localparam int PERIOD_W    = 8;
    localparam int MULT_W      = 12;
    localparam int MULT_FRAC   = 8;
    localparam int BAND_W      = PRICE_WIDTH + 2;
    // avg * (period - 1) + tr
    localparam int NUM_W       = PRICE_WIDTH + PERIOD_W + 1;
    localparam int CNT_W       = $clog2(NUM_W);
    localparam int PROD_W      = PRICE_WIDTH + MULT_W;
    localparam int OFF_W       = PROD_W - MULT_FRAC;
    localparam int SUM_W       = OFF_W + 2;

    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = MULT_W;

    localparam logic [CFG_IDX_W-1:0] REG_ATR_PERIOD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BAND_MULT  = CFG_IDX_W'(1);

    localparam logic [PERIOD_W-1:0] ATR_PERIOD_RST = PERIOD_W'(10);
    localparam logic [MULT_W-1:0]   BAND_MULT_RST  = MULT_W'(768);

    localparam logic signed [SUM_W-1:0] BAND_MAX_S = (SUM_W'(1) <<< (BAND_W - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] BAND_MIN_S = -BAND_MAX_S - SUM_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RANGE,
        ST_SUM,
        ST_DIV,
        ST_BARS,
        ST_BAND,
        ST_UPDATE
    } sts_state_t;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_LONG  = 2'd1,
        ACT_SHORT = 2'd2,
        ACT_CLOSE = 2'd3
    } sts_action_t;

    typedef enum logic [1:0] {
        SIDE_FLAT  = 2'd0,
        SIDE_LONG  = 2'd1,
        SIDE_SHORT = 2'd2
    } sts_side_t;

endpackage

[rtl/supertrend_signal.sv]
// channel   direction  handshake            payload
// in        input      in_valid / in_stall  bar_high, bar_low, bar_close
// out       output     out_valid / out_stall action, trend_up, bands_valid,
//                                           upper_level, lower_level, range_avg
// cfg       input      cfg_write            cfg_index, cfg_data
//
// a bar steps through ST_RANGE, ST_SUM, ST_DIV, ST_BARS, ST_BAND and ST_UPDATE,
// then out_valid rises and the next bar can be taken in that same cycle; the first
// bar ever skips the divide and goes from ST_SUM straight to ST_BARS
// the divide is a restoring divider, one quotient bit per cycle
// over the NUM_W-bit numerator avg * (period - 1) + tr
// one multiplier is shared between avg * (period - 1) and band_mult * avg
// reset clears all indicator state at once, no clearing pass
// a result sits in the output register while the next bar is accepted;
// a bar waits in its last step while the previous result is stalled
`include "supertrend_signal_macros.svh"

module supertrend_signal
    import sts_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [PRICE_WIDTH-1:0]       bar_high,
    input  logic [PRICE_WIDTH-1:0]       bar_low,
    input  logic [PRICE_WIDTH-1:0]       bar_close,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [1:0]                   action,
    output logic                         trend_up,
    output logic                         bands_valid,
    output logic signed [BAND_W-1:0]     upper_level,
    output logic signed [BAND_W-1:0]     lower_level,
    output logic [PRICE_WIDTH-1:0]       range_avg,
    input  logic                         cfg_write,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data
);

    sts_state_t state_reg, state_next;

    logic [PERIOD_W-1:0]       atr_period_reg;
    logic [MULT_W-1:0]         band_mult_reg;

    // indicator state
    logic [PRICE_WIDTH-1:0]    avg_reg;
    logic [PRICE_WIDTH-1:0]    last_close_reg;
    logic                      seeded_reg;
    logic [PERIOD_W-1:0]       bars_seen_reg;
    logic signed [BAND_W-1:0]  upper_reg;
    logic signed [BAND_W-1:0]  lower_reg;
    logic                      started_reg;
    logic [PRICE_WIDTH-1:0]    band_pc_reg;
    logic                      dir_reg;
    sts_side_t                 side_reg;

    // per-bar working registers
    logic [PRICE_WIDTH-1:0]    h_reg, l_reg, c_reg;
    logic [PRICE_WIDTH-1:0]    tr_reg;
    logic [PROD_W-1:0]         prod_reg;
    logic [NUM_W-1:0]          num_reg;
    logic [PERIOD_W-1:0]       rem_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [PRICE_WIDTH-1:0]    mid_reg;
    logic signed [BAND_W-1:0]  raw_up_reg, raw_lo_reg;

    // output register
    logic                      out_valid_reg;
    sts_action_t               action_reg;
    logic                      trend_reg;
    logic                      bands_valid_reg;
    logic signed [BAND_W-1:0]  upper_out_reg, lower_out_reg;
    logic [PRICE_WIDTH-1:0]    range_out_reg;

    logic                      in_fire, upd_fire;
    logic [PERIOD_W-1:0]       p_val;
    logic                      ready;

    logic [PRICE_WIDTH-1:0]    hl, da, db, tr_val;
    logic [MULT_W-1:0]         mul_b;
    logic [PROD_W-1:0]         mul_prod;
    logic [PERIOD_W:0]         trial, trial_diff;
    logic                      trial_ge;
    logic [PERIOD_W-1:0]       rem_next;
    logic [NUM_W-1:0]          num_next;
    logic [OFF_W-1:0]          off;
    logic signed [SUM_W-1:0]   mid_ext, off_ext;

    logic signed [BAND_W-1:0]  pc_s, close_s;
    logic signed [BAND_W-1:0]  upd_upper, upd_lower;
    logic                      upd_dir, upd_started;
    sts_side_t                 upd_side;
    sts_action_t               upd_action;

    function automatic logic [PRICE_WIDTH-1:0] abs_diff(
        input logic [PRICE_WIDTH-1:0] a,
        input logic [PRICE_WIDTH-1:0] b
    );
        return (a >= b) ? a - b : b - a;
    endfunction

    function automatic logic signed [BAND_W-1:0] clamp_band(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] r;
        r = v;
        if (v > BAND_MAX_S)
        begin
            r = BAND_MAX_S;
        end
        else if (v < BAND_MIN_S)
        begin
            r = BAND_MIN_S;
        end
        return r[BAND_W-1:0];
    endfunction

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_fire   = in_valid && !in_stall;
    assign upd_fire  = (state_reg == ST_UPDATE) && (!out_valid_reg || !out_stall);

    // a period of zero acts as one
    assign p_val = (atr_period_reg == '0) ? PERIOD_W'(1) : atr_period_reg;
    assign ready = (bars_seen_reg >= p_val);

    // true range, first bar uses high minus low alone
    always_comb
    begin
        hl     = (h_reg >= l_reg) ? h_reg - l_reg : '0;
        da     = abs_diff(h_reg, last_close_reg);
        db     = abs_diff(l_reg, last_close_reg);
        tr_val = hl;
        if (seeded_reg)
        begin
            if (da > tr_val)
            begin
                tr_val = da;
            end
            if (db > tr_val)
            begin
                tr_val = db;
            end
        end
    end

    // shared multiplier
    assign mul_b    = (state_reg == ST_RANGE) ? MULT_W'(p_val - PERIOD_W'(1)) : band_mult_reg;
    assign mul_prod = PROD_W'(avg_reg) * PROD_W'(mul_b);

    // restoring divide step, quotient shifts into num_reg
    assign trial      = {rem_reg, num_reg[NUM_W-1]};
    assign trial_diff = trial - {1'b0, p_val};
    assign trial_ge   = (trial >= {1'b0, p_val});
    assign rem_next   = trial_ge ? trial_diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
    assign num_next   = {num_reg[NUM_W-2:0], trial_ge};

    // band offset and raw bands
    assign off     = prod_reg[PROD_W-1:MULT_FRAC];
    assign mid_ext = signed'({{(SUM_W-PRICE_WIDTH){1'b0}}, mid_reg});
    assign off_ext = signed'({{(SUM_W-OFF_W){1'b0}}, off});

    // band update and position logic
    always_comb
    begin
        pc_s        = signed'({{(BAND_W-PRICE_WIDTH){1'b0}}, band_pc_reg});
        close_s     = signed'({{(BAND_W-PRICE_WIDTH){1'b0}}, c_reg});
        upd_upper   = upper_reg;
        upd_lower   = lower_reg;
        upd_dir     = dir_reg;
        upd_started = started_reg;
        upd_side    = side_reg;
        upd_action  = ACT_NONE;
        if (ready)
        begin
            if (!started_reg)
            begin
                upd_upper   = raw_up_reg;
                upd_lower   = raw_lo_reg;
                upd_started = 1'b1;
                upd_dir     = 1'b1;
            end
            else
            begin
                if ((raw_up_reg < upper_reg) || (pc_s > upper_reg))
                begin
                    upd_upper = raw_up_reg;
                end
                if ((raw_lo_reg > lower_reg) || (pc_s < lower_reg))
                begin
                    upd_lower = raw_lo_reg;
                end
                upd_dir = dir_reg ? !(close_s < upd_lower) : (close_s > upd_upper);
                // a reversal only closes; entries come from flat
                priority if (upd_dir && !dir_reg && side_reg == SIDE_FLAT)
                begin
                    upd_action = ACT_LONG;
                    upd_side   = SIDE_LONG;
                end
                else if (!upd_dir && dir_reg && side_reg == SIDE_FLAT)
                begin
                    upd_action = ACT_SHORT;
                    upd_side   = SIDE_SHORT;
                end
                else if (side_reg == SIDE_LONG && !upd_dir)
                begin
                    upd_action = ACT_CLOSE;
                    upd_side   = SIDE_FLAT;
                end
                else if (side_reg == SIDE_SHORT && upd_dir)
                begin
                    upd_action = ACT_CLOSE;
                    upd_side   = SIDE_FLAT;
                end
                else
                begin
                    upd_action = ACT_NONE;
                end
            end
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_RANGE;
                end
            end
            ST_RANGE:
            begin
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                state_next = seeded_reg ? ST_DIV : ST_BARS;
            end
            ST_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_BARS;
                end
            end
            ST_BARS:
            begin
                state_next = ST_BAND;
            end
            ST_BAND:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (upd_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // configuration and indicator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            atr_period_reg <= ATR_PERIOD_RST;
            band_mult_reg  <= BAND_MULT_RST;
            avg_reg        <= '0;
            last_close_reg <= '0;
            seeded_reg     <= 1'b0;
            bars_seen_reg  <= '0;
            upper_reg      <= '0;
            lower_reg      <= '0;
            started_reg    <= 1'b0;
            band_pc_reg    <= '0;
            dir_reg        <= 1'b1;
            side_reg       <= SIDE_FLAT;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == REG_ATR_PERIOD)
                begin
                    atr_period_reg <= cfg_data[PERIOD_W-1:0];
                end
                else if (cfg_index == REG_BAND_MULT)
                begin
                    band_mult_reg <= cfg_data[MULT_W-1:0];
                end
            end

            if (state_reg == ST_SUM && !seeded_reg)
            begin
                avg_reg    <= tr_reg;
                seeded_reg <= 1'b1;
            end
            if (state_reg == ST_DIV && cnt_reg == '0)
            begin
                avg_reg <= num_next[PRICE_WIDTH-1:0];
            end
            if (state_reg == ST_BARS)
            begin
                last_close_reg <= c_reg;
                if (bars_seen_reg < p_val)
                begin
                    bars_seen_reg <= bars_seen_reg + PERIOD_W'(1);
                end
            end
            if (upd_fire)
            begin
                upper_reg   <= upd_upper;
                lower_reg   <= upd_lower;
                started_reg <= upd_started;
                dir_reg     <= upd_dir;
                side_reg    <= upd_side;
                if (ready)
                begin
                    band_pc_reg <= c_reg;
                end
            end

            if (upd_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // working and output payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            h_reg <= bar_high;
            l_reg <= bar_low;
            c_reg <= bar_close;
        end
        if (state_reg == ST_RANGE)
        begin
            tr_reg   <= tr_val;
            prod_reg <= mul_prod;
        end
        if (state_reg == ST_SUM)
        begin
            num_reg <= prod_reg[NUM_W-1:0] + NUM_W'(tr_reg);
            rem_reg <= '0;
            cnt_reg <= CNT_W'(NUM_W - 1);
        end
        if (state_reg == ST_DIV)
        begin
            num_reg <= num_next;
            rem_reg <= rem_next;
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
        if (state_reg == ST_BARS)
        begin
            prod_reg <= mul_prod;
            mid_reg  <= PRICE_WIDTH'(({1'b0, h_reg} + {1'b0, l_reg}) >> 1);
        end
        if (state_reg == ST_BAND)
        begin
            raw_up_reg <= clamp_band(mid_ext + off_ext);
            raw_lo_reg <= clamp_band(mid_ext - off_ext);
        end
        if (upd_fire)
        begin
            action_reg      <= upd_action;
            trend_reg       <= upd_dir;
            bands_valid_reg <= upd_started;
            upper_out_reg   <= upd_upper;
            lower_out_reg   <= upd_lower;
            range_out_reg   <= ready ? avg_reg : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign action      = action_reg;
    assign trend_up    = trend_reg;
    assign bands_valid = bands_valid_reg;
    assign upper_level = upper_out_reg;
    assign lower_level = lower_out_reg;
    assign range_avg   = range_out_reg;

    // divider remainder stays below the period
    `STS_ASSERT_IMP(a_rem_bound, state_reg == ST_DIV, rem_reg < p_val)
    // a long position only while the trend is up, short only while down
    `STS_ASSERT_IMP(a_long_up, side_reg == SIDE_LONG, dir_reg)
    `STS_ASSERT_IMP(a_short_down, side_reg == SIDE_SHORT, !dir_reg)
    // bands are never started before the average is seeded
    `STS_ASSERT_IMP(a_started_seeded, started_reg, seeded_reg && bars_seen_reg != '0)
    // a finished update always lands in the output register
    `STS_ASSERT_NXT(a_update_out, upd_fire, out_valid_reg && state_reg == ST_IDLE)

endmodule
